/* hdl/brp_pkg.sv */
package brp_pkg;

  // offset width; all byte numbers and lengths use it
  localparam int OFF_BITS = 48;
  localparam int MAC_BITS = OFF_BITS + 4;
  localparam logic [OFF_BITS-1:0] OFF_MAX = '1;

  localparam int PREFIX_LEN = 6;  // "bytes="

  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'
  localparam logic [7:0] CH_DASH = 8'h2D;  // '-'

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_LOW    = 4'b0010,
    PH_HIGH   = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_t;

  // parse state captured on the final character
  typedef struct packed {
    phase_t              phase;
    logic [OFF_BITS-1:0] low;
    logic [OFF_BITS-1:0] high;
    logic                saw_low;
    logic                saw_high;
  } snap_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h62;  // b
      3'd1:    c = 8'h79;  // y
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h73;  // s
      3'd5:    c = 8'h3D;  // =
      default: c = 8'h00;
    endcase
    prefix_char = c;
  endfunction

  // acc * 10 + d, saturating at OFF_MAX
  function automatic logic [OFF_BITS-1:0] mac10(input logic [OFF_BITS-1:0] acc,
                                                input logic [3:0] d);
    logic [MAC_BITS-1:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + MAC_BITS'(d);
    if (sum[MAC_BITS-1:OFF_BITS] != '0) begin
      mac10 = OFF_MAX;
    end else begin
      mac10 = sum[OFF_BITS-1:0];
    end
  endfunction

endpackage

/* hdl/brp_in_if.sv */
interface brp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

/* hdl/brp_out_if.sv */
interface brp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         partial;
  logic [brp_pkg::OFF_BITS-1:0] first_byte;
  logic [brp_pkg::OFF_BITS-1:0] last_byte;
  logic [brp_pkg::OFF_BITS-1:0] span_length;

  modport source (output valid, output partial, output first_byte, output last_byte,
                  output span_length, input ready);
  modport sink   (input valid, input partial, input first_byte, input last_byte,
                  input span_length, output ready);
endinterface

/* hdl/brp_parse.sv */
module brp_parse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [brp_pkg::OFF_BITS-1:0] obj_len,
  brp_in_if.sink                       hdr,
  output logic                         snap_valid,
  input  logic                         snap_ready,
  output brp_pkg::snap_t               snap
);

  // input register
  logic       in_v;
  logic [7:0] in_char;
  logic       in_last;
  logic       in_go;

  // parse state
  brp_pkg::phase_t             phase, phase_next;
  logic [2:0]                  prefix_pos, prefix_pos_next;
  logic [brp_pkg::OFF_BITS-1:0] low_acc, low_acc_next;
  logic [brp_pkg::OFF_BITS-1:0] high_acc, high_acc_next;
  logic                        saw_low, saw_low_next;
  logic                        saw_high, saw_high_next;

  logic       is_digit;
  logic [3:0] digit;

  // the last word needs the snapshot slot free; nothing is taken in reset
  assign in_go     = in_v && (!in_last || !snap_valid || snap_ready);
  assign hdr.ready = !rst && (!in_v || in_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (hdr.ready) begin
      in_v <= hdr.valid;
    end
    if (hdr.ready && hdr.valid) begin
      in_char <= hdr.char_in;
      in_last <= hdr.last_char;
    end
  end

  assign is_digit = (in_char >= brp_pkg::CH_ZERO) && (in_char <= brp_pkg::CH_NINE);
  assign digit    = in_char[3:0];

  always_comb begin
    phase_next      = phase;
    prefix_pos_next = prefix_pos;
    low_acc_next    = low_acc;
    high_acc_next   = high_acc;
    saw_low_next    = saw_low;
    saw_high_next   = saw_high;
    unique case (phase)
      brp_pkg::PH_PREFIX: begin
        if ((prefix_pos < 3'(brp_pkg::PREFIX_LEN)) &&
            (in_char == brp_pkg::prefix_char(prefix_pos))) begin
          prefix_pos_next = prefix_pos + 3'd1;
          if (prefix_pos_next == 3'(brp_pkg::PREFIX_LEN)) begin
            phase_next = brp_pkg::PH_LOW;
          end
        end else begin
          phase_next = brp_pkg::PH_FAIL;
        end
      end
      brp_pkg::PH_LOW: begin
        if (is_digit) begin
          low_acc_next = brp_pkg::mac10(low_acc, digit);
          saw_low_next = 1'b1;
        end else if ((low_acc >= obj_len) || (in_char != brp_pkg::CH_DASH)) begin
          phase_next = brp_pkg::PH_FAIL;
        end else begin
          phase_next = brp_pkg::PH_HIGH;
        end
      end
      brp_pkg::PH_HIGH: begin
        if (is_digit) begin
          high_acc_next = brp_pkg::mac10(high_acc, digit);
          saw_high_next = 1'b1;
        end else begin
          phase_next = brp_pkg::PH_FAIL;
        end
      end
      default: begin
        phase_next = brp_pkg::PH_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= brp_pkg::PH_PREFIX;
      prefix_pos <= '0;
      low_acc    <= '0;
      high_acc   <= '0;
      saw_low    <= 1'b0;
      saw_high   <= 1'b0;
      snap_valid <= 1'b0;
    end else begin
      if (in_go) begin
        if (in_last) begin
          phase      <= brp_pkg::PH_PREFIX;
          prefix_pos <= '0;
          low_acc    <= '0;
          high_acc   <= '0;
          saw_low    <= 1'b0;
          saw_high   <= 1'b0;
        end else begin
          phase      <= phase_next;
          prefix_pos <= prefix_pos_next;
          low_acc    <= low_acc_next;
          high_acc   <= high_acc_next;
          saw_low    <= saw_low_next;
          saw_high   <= saw_high_next;
        end
      end
      if (in_go && in_last) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
    if (in_go && in_last) begin
      snap.phase    <= phase_next;
      snap.low      <= low_acc_next;
      snap.high     <= high_acc_next;
      snap.saw_low  <= saw_low_next;
      snap.saw_high <= saw_high_next;
    end
  end

endmodule

/* hdl/brp_span.sv */
module brp_span (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [brp_pkg::OFF_BITS-1:0] obj_len,
  input  logic                         snap_valid,
  output logic                         snap_ready,
  input  brp_pkg::snap_t               snap,
  brp_out_if.source                    rng
);

  // clamp stage
  logic                         c_v;
  logic                         c_pre_ok;
  logic [brp_pkg::OFF_BITS-1:0] c_lo;
  logic [brp_pkg::OFF_BITS-1:0] c_hi;
  logic [brp_pkg::OFF_BITS-1:0] c_dflt_last;
  logic                         calc_go;

  // output register
  logic                         o_v;
  logic                         o_partial;
  logic [brp_pkg::OFF_BITS-1:0] o_first;
  logic [brp_pkg::OFF_BITS-1:0] o_last;
  logic [brp_pkg::OFF_BITS-1:0] o_span;

  logic                         len_nz;
  logic [brp_pkg::OFF_BITS-1:0] top;
  logic [brp_pkg::OFF_BITS-1:0] suffix_lo;
  logic [brp_pkg::OFF_BITS-1:0] lo_next;
  logic [brp_pkg::OFF_BITS-1:0] hi_next;
  logic                         ok;
  logic [brp_pkg::OFF_BITS-1:0] span;

  assign calc_go    = c_v && (!o_v || rng.ready);
  assign snap_ready = !c_v || calc_go;

  assign len_nz    = obj_len != '0;
  assign top       = obj_len - brp_pkg::OFF_BITS'(1);
  // suffix form: last n bytes, whole object when n runs past the start
  assign suffix_lo = (snap.high > obj_len) ? '0 : obj_len - snap.high;
  assign lo_next   = (snap.saw_high && !snap.saw_low) ? suffix_lo : snap.low;
  assign hi_next   = (snap.saw_high && snap.saw_low && !(snap.high > top)) ? snap.high : top;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      c_v <= 1'b1;
    end else if (calc_go) begin
      c_v <= 1'b0;
    end
    if (snap_valid && snap_ready) begin
      c_pre_ok    <= (snap.phase == brp_pkg::PH_HIGH) && len_nz;
      c_lo        <= lo_next;
      c_hi        <= hi_next;
      c_dflt_last <= len_nz ? top : '0;
    end
  end

  assign ok   = c_pre_ok && (c_lo <= c_hi);
  assign span = c_hi - c_lo + brp_pkg::OFF_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (calc_go) begin
      o_v <= 1'b1;
    end else if (rng.ready) begin
      o_v <= 1'b0;
    end
    if (calc_go) begin
      o_partial <= ok;
      o_first   <= ok ? c_lo : '0;
      o_last    <= ok ? c_hi : c_dflt_last;
      o_span    <= ok ? span : obj_len;
    end
  end

  assign rng.valid       = o_v;
  assign rng.partial     = o_partial;
  assign rng.first_byte  = o_first;
  assign rng.last_byte   = o_last;
  assign rng.span_length = o_span;

endmodule

/* hdl/http_byte_range_parser_core.sv */
// HTTP Range header parser. Characters of the header value come in one
// word per cycle on hdr (last_char set on the final one) unless the last
// character stalls on rng back-pressure; one result word per value leaves
// on rng after the last character. The value must read "bytes=" then an
// optional first byte, '-', and an optional last byte; "a-b", "a-" and
// "-n" are handled, numbers saturate at 2^48-1. Anything else, a first
// byte at or past the object length, or an inverted range gives partial=0
// with the full object; a last byte past the end is clamped, and a suffix
// longer than the object starts at byte 0. Rate: one character per cycle,
// with no gap between values, while rng does not hold off results.
// Each character costs one pass through the parse step (a 48-bit
// multiply-by-ten-and-add plus a compare); the result passes the input
// register, parse snapshot, clamp and output register. Write object_length
// through cfg_wr_en/cfg_wr_data only while no value is in flight.
module http_byte_range_parser_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [brp_pkg::OFF_BITS-1:0] cfg_wr_data,
  brp_in_if.sink                       hdr,
  brp_out_if.source                    rng
);

  // object length register
  logic [brp_pkg::OFF_BITS-1:0] object_length;

  // parse -> clamp handoff
  logic           snap_valid;
  logic           snap_ready;
  brp_pkg::snap_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_length <= '0;
    end else if (cfg_wr_en) begin
      object_length <= cfg_wr_data;
    end
  end

  // per-character state machine; snapshots its state on the last word
  brp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .obj_len    (object_length),
    .hdr        (hdr),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // range resolution: suffix, clamp, validity check, span
  brp_span u_span (
    .clk        (clk),
    .rst        (rst),
    .obj_len    (object_length),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .rng        (rng)
  );

endmodule

/* tb/http_byte_range_parser_core_test.sv */
`timescale 1ns / 100ps

module http_byte_range_parser_core_test;
  import brp_pkg::*;

  // one result word as the block should present it
  typedef struct packed {
    logic                partial;
    logic [OFF_BITS-1:0] first_byte;
    logic [OFF_BITS-1:0] last_byte;
    logic [OFF_BITS-1:0] span_length;
  } span_word_t;

  // receiver stall styles
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_style_t;

  localparam int SETTLE = 6;  // covers the pipeline depth with margin on top

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [OFF_BITS-1:0] cfg_wr_data;

  brp_in_if  hdr_if ();
  brp_out_if rng_if ();

  http_byte_range_parser_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .hdr         (hdr_if),
    .rng         (rng_if)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Parser shadow: same state the block keeps, advanced on every accepted
  // header word. A closing word (last_char) produces one expected span.
  // ---------------------------------------------------------------------
  string               unit_tag = "bytes=";
  logic [OFF_BITS-1:0] obj_len;
  phase_t              parse_ph;
  int                  unit_pos;
  logic [OFF_BITS-1:0] lo_acc;
  logic [OFF_BITS-1:0] hi_acc;
  bit                  saw_lo;
  bit                  saw_hi;

  span_word_t pending_spans[$];

  // bookkeeping for the summary
  int errors;
  int chars_sent;
  int words_seen;
  int partial_seen;
  int len_writes;

  // sender pacing
  bit tx_bursty;
  int burst_left;
  rx_style_t rx_mode;
  int unsigned rx_cnt;

  // value under construction, as raw bytes (NUL must survive)
  logic [7:0] word_q[$];

  // decimal accumulate, pinned at the all-ones offset on overflow
  function automatic logic [OFF_BITS-1:0] dec_push(input logic [OFF_BITS-1:0] acc,
                                                   input logic [3:0] d);
    logic [63:0] wide;
    wide = 64'(acc) * 64'd10 + 64'(d);
    if (wide > 64'(OFF_MAX)) begin
      return OFF_MAX;
    end
    return wide[OFF_BITS-1:0];
  endfunction

  task automatic clear_parse();
    parse_ph = PH_PREFIX;
    unit_pos = 0;
    lo_acc   = '0;
    hi_acc   = '0;
    saw_lo   = 1'b0;
    saw_hi   = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c, input bit lst);
    bit                  is_dig;
    bit                  ok;
    logic [OFF_BITS-1:0] top;
    logic [OFF_BITS-1:0] lo;
    logic [OFF_BITS-1:0] hi;
    span_word_t          w;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    case (parse_ph)
      PH_PREFIX: begin
        if (unit_pos < PREFIX_LEN && c == unit_tag[unit_pos]) begin
          unit_pos++;
          if (unit_pos == PREFIX_LEN) parse_ph = PH_LOW;
        end else begin
          parse_ph = PH_FAIL;
        end
      end
      PH_LOW: begin
        if (is_dig) begin
          lo_acc = dec_push(lo_acc, 4'(c - CH_ZERO));
          saw_lo = 1'b1;
        end else if (lo_acc >= obj_len || c != CH_DASH) begin
          parse_ph = PH_FAIL;
        end else begin
          parse_ph = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (is_dig) begin
          hi_acc = dec_push(hi_acc, 4'(c - CH_ZERO));
          saw_hi = 1'b1;
        end else begin
          parse_ph = PH_FAIL;
        end
      end
      default: parse_ph = PH_FAIL;
    endcase
    if (!lst) return;

    ok = 1'b0;
    lo = '0;
    hi = '0;
    if (parse_ph == PH_HIGH && obj_len != '0) begin
      top = obj_len - OFF_BITS'(1);
      lo  = lo_acc;
      if (saw_hi && !saw_lo) begin
        // suffix form: last n bytes, whole object when n is too big
        lo = (hi_acc > obj_len) ? '0 : obj_len - hi_acc;
        hi = top;
      end else if (saw_hi) begin
        hi = hi_acc;
      end else begin
        hi = top;  // open-ended
      end
      if (hi > top) hi = top;
      ok = (lo <= hi);
    end
    if (ok) begin
      w.partial     = 1'b1;
      w.first_byte  = lo;
      w.last_byte   = hi;
      w.span_length = hi - lo + OFF_BITS'(1);
    end else begin
      w.partial     = 1'b0;
      w.first_byte  = '0;
      w.last_byte   = (obj_len != '0) ? obj_len - OFF_BITS'(1) : '0;
      w.span_length = obj_len;
    end
    pending_spans.push_back(w);
    clear_parse();
  endtask

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // one header word; returns on the edge where it was taken. In bursty
  // mode a random gap follows the end of each burst.
  task automatic send_char(input logic [7:0] c, input bit lst);
    int gap;
    hdr_if.valid     <= 1'b1;
    hdr_if.char_in   <= c;
    hdr_if.last_char <= lst;
    @(posedge clk);
    while (!hdr_if.ready) @(posedge clk);
    parse_char(c, lst);
    chars_sent++;
    if (!tx_bursty) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        hdr_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) word_q.push_back(s[i]);
  endtask

  task automatic send_value();
    foreach (word_q[i]) send_char(word_q[i], i == word_q.size() - 1);
    word_q.delete();
  endtask

  task automatic send_text(input string s);
    put_text(s);
    send_value();
  endtask

  task automatic put_nines(input int n);
    repeat (n) word_q.push_back(CH_NINE);
  endtask

  // hold the sender until every expected span has come back
  task automatic wait_drain();
    hdr_if.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  task automatic set_length(input logic [OFF_BITS-1:0] v);
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    obj_len = v;
    len_writes++;
  endtask

  // a decimal number aimed at the interesting spots around obj_len
  task automatic put_number();
    logic [OFF_BITS-1:0] v;
    logic [63:0]         r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 8))
      0: v = OFF_BITS'($urandom_range(0, 20));
      1: v = obj_len;
      2: v = obj_len - OFF_BITS'(1);
      3: v = obj_len + OFF_BITS'(1);
      4: v = (obj_len == '0) ? '0 : r[OFF_BITS-1:0] % obj_len;
      5: v = r[OFF_BITS-1:0];
      6: v = OFF_BITS'($urandom_range(0, 5000));
      7: begin
        // leading zeros in front of a small number
        put_text("00");
        v = OFF_BITS'($urandom_range(0, 99));
      end
      default: begin
        // long digit run, can saturate the accumulator
        repeat ($urandom_range(15, 20)) word_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        return;
      end
    endcase
    put_text($sformatf("%0d", v));
  endtask

  task automatic put_range();
    put_text("bytes=");
    case ($urandom_range(0, 3))
      0: begin put_number(); put_text("-"); put_number(); end
      1: begin put_number(); put_text("-"); end
      2: begin put_text("-"); put_number(); end
      default: put_text("-");
    endcase
  endtask

  // mostly well-formed ranges with random content, the rest broken
  task automatic send_random_value();
    int pos;
    case ($urandom_range(0, 9))
      6: begin
        put_range();
        word_q[$urandom_range(0, PREFIX_LEN - 1)] = 8'($urandom_range(0, 255));
      end
      7: begin
        put_range();
        pos = $urandom_range(1, word_q.size());
        while (word_q.size() > pos) void'(word_q.pop_back());
      end
      8: begin
        put_range();
        pos = $urandom_range(0, word_q.size());
        word_q.insert(pos, 8'($urandom_range(0, 255)));
      end
      9: repeat ($urandom_range(1, 8)) word_q.push_back(8'($urandom_range(0, 255)));
      default: put_range();
    endcase
    send_value();
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: checks each accepted range word against the oldest
  // expectation, then picks ready for the next edge.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [OFF_BITS-1:0] exp_v,
                             input logic [OFF_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin : rx_side
    span_word_t exp_w;
    rng_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rng_if.valid && rng_if.ready) begin
        if (pending_spans.size() == 0) begin
          errors++;
          $display("%0t: range word with nothing expected, expected none, got partial=%0d %0d..%0d",
                   $time, rng_if.partial, rng_if.first_byte, rng_if.last_byte);
        end else begin
          exp_w = pending_spans.pop_front();
          check_field("partial", OFF_BITS'(exp_w.partial), OFF_BITS'(rng_if.partial));
          check_field("first_byte", exp_w.first_byte, rng_if.first_byte);
          check_field("last_byte", exp_w.last_byte, rng_if.last_byte);
          check_field("span_length", exp_w.span_length, rng_if.span_length);
          words_seen++;
          if (exp_w.partial) partial_seen++;
        end
      end
      rx_cnt++;
      case (rx_mode)
        RX_OPEN:   rng_if.ready <= 1'b1;
        RX_RANDOM: rng_if.ready <= ($urandom_range(0, 99) < 60);
        default:   rng_if.ready <= (rx_cnt % 23) > 8;  // periodic stall pattern
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // the three range forms, clamping, inversion and junk on a 1000 byte object
  task automatic test_forms();
    tx_bursty = 1'b1;
    rx_mode   = RX_RANDOM;
    set_length(48'd1000);
    send_text("bytes=0-499");
    send_text("bytes=500-");
    send_text("bytes=-200");
    send_text("bytes=-2000");   // suffix past the object: starts at 0
    send_text("bytes=-0");      // zero suffix is inverted
    send_text("bytes=1000-");   // first byte at the length
    send_text("bytes=999-999");
    send_text("bytes=5-3");     // inverted
    send_text("bytes=0-5000");  // last byte clamped
    send_text("bytes=0-5x");    // trailing junk
    put_text("bytes=7-");       // NUL counts as junk
    word_q.push_back(8'h00);
    send_value();
    put_text("bytes=0-1");      // all-ones byte
    word_q.push_back(8'hFF);
    send_value();
    send_text("byt");           // ends inside the prefix
    send_text("bytes=12");      // ends before the dash
    send_text("bytes=-");
    send_text("Bytes=0-1");
  endtask

  task automatic test_edge_lengths();
    rx_mode = RX_PATTERN;
    set_length('0);  // empty object: nothing is ever partial
    send_text("bytes=0-0");
    send_text("bytes=-5");
    set_length(48'd1);
    send_text("bytes=0-0");
    set_length(OFF_MAX);
    put_text("bytes=");         // saturated first byte lands on the length
    put_nines(25);
    put_text("-");
    send_value();
    send_text("bytes=281474976710654-");
    put_text("bytes=0-");
    put_nines(25);
    send_value();
    put_text("bytes=-");        // saturated suffix equals the length
    put_nines(25);
    send_value();
  endtask

  // full rate both ways, with a pause that lets everything drain, then a stalling receiver
  task automatic test_back_to_back();
    tx_bursty = 1'b0;
    rx_mode   = RX_OPEN;
    set_length(48'd4096);
    repeat (6) send_random_value();
    wait_drain();
    repeat (6) send_random_value();
    rx_mode = RX_PATTERN;
    repeat (6) send_random_value();
  endtask

  task automatic test_random(input int budget);
    logic [OFF_BITS-1:0] lens[6];
    logic [63:0]         r;
    int                  stop_at;
    r       = {$urandom(), $urandom()};
    lens[0] = 48'd1;
    lens[1] = OFF_BITS'($urandom_range(2, 5000));
    lens[2] = r[OFF_BITS-1:0];
    lens[3] = OFF_MAX;
    lens[4] = '0;
    lens[5] = OFF_BITS'($urandom_range(1, 1 << 20));
    foreach (lens[i]) begin
      set_length(lens[i]);
      tx_bursty = (i % 3) != 2;
      rx_mode   = rx_style_t'(i % 3);
      stop_at   = chars_sent + budget / 6;
      while (chars_sent < stop_at) send_random_value();
    end
  endtask

  initial begin : main
    errors       = 0;
    chars_sent   = 0;
    words_seen   = 0;
    partial_seen = 0;
    len_writes   = 0;
    burst_left   = 0;
    rx_cnt       = 0;
    tx_bursty    = 1'b0;
    rx_mode      = RX_OPEN;
    obj_len      = '0;
    clear_parse();
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    hdr_if.valid     <= 1'b0;
    hdr_if.char_in   <= '0;
    hdr_if.last_char <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_forms();
    test_edge_lengths();
    test_back_to_back();
    test_random(240);

    wait_drain();
    repeat (2 * SETTLE) @(posedge clk);
    $display("covered %0d header chars, %0d range words (%0d partial), %0d length writes",
             chars_sent, words_seen, partial_seen, len_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/brp_pkg.sv
hdl/brp_in_if.sv
hdl/brp_out_if.sv
hdl/brp_parse.sv
hdl/brp_span.sv
hdl/http_byte_range_parser_core.sv
tb/http_byte_range_parser_core_test.sv
